### rtl/ego_pkg.sv
package ego_pkg;

   localparam int WORD_W         = 32;
   localparam int VALUE_W        = 16;
   localparam int COUNT_W        = 6;
   localparam int CMD_W          = 2;
   localparam int VALUE_BITS_DEF = 16;

   localparam logic [CMD_W-1:0] CMD_RAW    = 2'd0;
   localparam logic [CMD_W-1:0] CMD_ENCODE = 2'd1;
   localparam logic [CMD_W-1:0] CMD_FLUSH  = 2'd2;

   // one code ready for packing: bits already reversed, first bit at bit 0
   typedef struct packed {
      logic               emit;
      logic               flush;
      logic [COUNT_W-1:0] len;
      logic [WORD_W-1:0]  bits;
   } ego_code_type;

endpackage

### rtl/ego_req_if.sv
interface ego_req_if;
   logic                         valid;
   logic                         ready;
   logic [ego_pkg::CMD_W-1:0]    command;
   logic [ego_pkg::VALUE_W-1:0]  value;
   logic [ego_pkg::WORD_W-1:0]   raw_bits;
   logic [ego_pkg::COUNT_W-1:0]  raw_count;

   modport source (output valid, output command, output value, output raw_bits,
                   output raw_count, input ready);
   modport sink   (input valid, input command, input value, input raw_bits,
                   input raw_count, output ready);
endinterface

### rtl/ego_rsp_if.sv
interface ego_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [ego_pkg::WORD_W-1:0]   out_word;
   logic [ego_pkg::COUNT_W-1:0]  valid_bits;

   modport source (output valid, output out_word, output valid_bits, input ready);
   modport sink   (input valid, input out_word, input valid_bits, output ready);
endinterface

### rtl/ego_code_gen.sv
module ego_code_gen #(
   parameter int VALUE_BITS = ego_pkg::VALUE_BITS_DEF
) (
   input  logic [ego_pkg::CMD_W-1:0]   command,
   input  logic [ego_pkg::VALUE_W-1:0] value,
   input  logic [ego_pkg::WORD_W-1:0]  raw_bits,
   input  logic [ego_pkg::COUNT_W-1:0] raw_count,
   output ego_pkg::ego_code_type       code
);
   import ego_pkg::*;

   // largest value whose code fits in 2*VALUE_BITS-1 bits
   localparam logic [VALUE_W:0] VMAX = (VALUE_W+1)'((1 << VALUE_BITS) - 2);

   logic [COUNT_W-1:0] cnt;
   logic [WORD_W-1:0]  raw_mask;
   logic [VALUE_W:0]   v_sat;
   logic [VALUE_W:0]   c_val;
   logic [4:0]         n_len;
   logic [COUNT_W-1:0] len;
   logic [WORD_W-1:0]  msb_code;
   logic [WORD_W-1:0]  rev;

   always_comb begin
      cnt      = (raw_count > COUNT_W'(WORD_W)) ? COUNT_W'(WORD_W) : raw_count;
      raw_mask = {WORD_W{1'b1}} >> (COUNT_W'(WORD_W) - cnt);

      v_sat = ({1'b0, value} > VMAX) ? VMAX : {1'b0, value};
      c_val = v_sat + (VALUE_W+1)'(1);
      n_len = '0;
      for (int i = 0; i < VALUE_W + 1; i++) begin
         if (c_val[i]) n_len = 5'(i + 1);
      end

      code.emit  = 1'b0;
      code.flush = 1'b0;
      len        = cnt;
      msb_code   = raw_bits & raw_mask;
      case (command)
         CMD_RAW: begin
            code.emit = (cnt != '0);
         end
         CMD_ENCODE: begin
            code.emit = 1'b1;
            len       = {n_len, 1'b0} - COUNT_W'(1);
            msb_code  = WORD_W'(c_val);
         end
         CMD_FLUSH: begin
            code.flush = 1'b1;
         end
         default: begin
            code.emit = 1'b0;
         end
      endcase

      // MSB-first code becomes LSB-first bits for packing upward
      for (int i = 0; i < WORD_W; i++) begin
         rev[i] = msb_code[WORD_W-1-i];
      end
      code.len  = len;
      code.bits = rev >> (COUNT_W'(WORD_W) - len);
   end

endmodule

### rtl/ego_packer.sv
module ego_packer (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  item_valid,
   input  ego_pkg::ego_code_type code,
   output logic                  item_taken,
   ego_rsp_if.source             rsp_ch
);
   import ego_pkg::*;

   logic [WORD_W-1:0]   acc_ff, acc_in;
   logic [4:0]          fill_ff, fill_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [WORD_W-1:0]   word_ff, word_in;
   logic [COUNT_W-1:0]  vbits_ff, vbits_in;
   logic [2*WORD_W-1:0] merged;
   logic [COUNT_W-1:0]  sum;

   assign item_taken = item_valid && (!rsp_valid_ff || rsp_ch.ready);

   always_comb begin
      merged = {{WORD_W{1'b0}}, acc_ff} | ({{WORD_W{1'b0}}, code.bits} << fill_ff);
      sum    = {1'b0, fill_ff} + code.len;

      acc_in       = acc_ff;
      fill_in      = fill_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      word_in      = word_ff;
      vbits_in     = vbits_ff;

      if (item_taken) begin
         if (code.flush) begin
            if (fill_ff != '0) begin
               word_in      = acc_ff;
               vbits_in     = {1'b0, fill_ff};
               rsp_valid_in = 1'b1;
               acc_in       = '0;
               fill_in      = '0;
            end
         end else if (code.emit) begin
            fill_in = sum[4:0];
            if (sum[5]) begin
               word_in      = merged[WORD_W-1:0];
               vbits_in     = COUNT_W'(WORD_W);
               rsp_valid_in = 1'b1;
               acc_in       = merged[2*WORD_W-1:WORD_W];
            end else begin
               acc_in = merged[WORD_W-1:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff       <= '0;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         acc_ff       <= acc_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      word_ff  <= word_in;
      vbits_ff <= vbits_in;
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.out_word   = word_ff;
   assign rsp_ch.valid_bits = vbits_ff;

endmodule

### rtl/exp_golomb_bit_packer.sv
// A word accepted on req_ch passes the input register, the code and pack logic
// and the result register before any result it makes shows on rsp_ch.
// Throughput: 1 word per cycle, sustained while rsp_ch takes results.
// One input register and one result register lie around the pack logic.
// Reset: synchronous, active high; clears the accumulator, the fill count and
// both valid flags. Payload registers are not reset.
module exp_golomb_bit_packer #(
   parameter int VALUE_BITS = ego_pkg::VALUE_BITS_DEF
) (
   input  logic      clock,
   input  logic      reset,
   ego_req_if.sink   req_ch,
   ego_rsp_if.source rsp_ch
);
   import ego_pkg::*;

   // input register stage
   logic               s1_valid_ff, s1_valid_in;
   logic [CMD_W-1:0]   s1_command_ff;
   logic [VALUE_W-1:0] s1_value_ff;
   logic [WORD_W-1:0]  s1_raw_bits_ff;
   logic [COUNT_W-1:0] s1_raw_count_ff;

   logic               req_take;
   logic               item_taken;
   ego_code_type       code;

   // stage frees up when its word is consumed by the packer this cycle
   assign req_ch.ready = !s1_valid_ff || item_taken;
   assign req_take     = req_ch.valid && req_ch.ready;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (item_taken) s1_valid_in = 1'b0;
      if (req_take)   s1_valid_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   // payload held until the stage reloads
   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_command_ff   <= req_ch.command;
         s1_value_ff     <= req_ch.value;
         s1_raw_bits_ff  <= req_ch.raw_bits;
         s1_raw_count_ff <= req_ch.raw_count;
      end
   end

   // code formation: raw mask or exp-Golomb code, bit reversed for packing
   ego_code_gen #(
      .VALUE_BITS (VALUE_BITS)
   ) u_code_gen (
      .command   (s1_command_ff),
      .value     (s1_value_ff),
      .raw_bits  (s1_raw_bits_ff),
      .raw_count (s1_raw_count_ff),
      .code      (code)
   );

   // accumulator, word completion / flush, result register
   ego_packer u_packer (
      .clock      (clock),
      .reset      (reset),
      .item_valid (s1_valid_ff),
      .code       (code),
      .item_taken (item_taken),
      .rsp_ch     (rsp_ch)
   );

endmodule

### rtl/ego_checker.sv
module ego_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] out_word,
   input logic [5:0]  valid_bits
);

   // result holds while stalled
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(out_word) && $stable(valid_bits))
      else $error("result changed while stalled");

   a_vbits_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> valid_bits != 6'd0 && valid_bits <= 6'd32)
      else $error("valid_bits out of range");

   // bits beyond the filled part of a flushed word are clear
   a_word_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && valid_bits < 6'd32 |-> (out_word >> valid_bits) == 32'd0)
      else $error("stray bits above valid_bits");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result shown straight after reset");

endmodule

bind exp_golomb_bit_packer ego_checker u_ego_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_valid  (rsp_ch.valid),
   .rsp_ready  (rsp_ch.ready),
   .out_word   (rsp_ch.out_word),
   .valid_bits (rsp_ch.valid_bits)
);

### tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
   import ego_pkg::*;

   // command code the block has to ignore
   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

   // largest value whose code fits, matching the block's VALUE_BITS
   localparam logic [VALUE_W-1:0] VALUE_SAT = VALUE_W'((1 << VALUE_BITS_DEF) - 2);

   // cycles with no word moving on either channel before the run is abandoned;
   // a quiet stretch comes from a sender gap, sink stalls and the path through the block
   localparam int STALL_LIMIT = 500;

   // the path through the block, plus margin, for the drain at the end
   localparam int TAIL_CYCLES = 8;

   typedef struct packed {
      logic [WORD_W-1:0]  word;
      logic [COUNT_W-1:0] nbits;
   } packed_word_type;

   logic clock;
   logic reset;

   ego_req_if req_if ();
   ego_rsp_if rsp_if ();

   exp_golomb_bit_packer i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_if),
      .rsp_ch (rsp_if)
   );

   // packer state as predicted
   logic [WORD_W-1:0] acc_bits;
   logic [4:0]        acc_fill;

   packed_word_type expected_words[$];
   int              fault_count;
   int              quiet_cycles;

   // idling switches for each side
   bit src_idle_on;
   bit snk_idle_on;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // ---------------------------------------------------------------------------
   // Prediction
   // ---------------------------------------------------------------------------

   // Append len bits of code, highest first, at the current fill position. At
   // most one full word can come out; leftover bits start the next word.
   task automatic append_code(input logic [63:0] code, input int len);
      logic [63:0]     stash;
      int              pos;
      packed_word_type full;
      stash = {32'd0, acc_bits};
      pos   = int'(acc_fill);
      for (int i = 0; i < len; i++) begin
         stash[pos] = code[len-1-i];
         pos++;
      end
      if (pos >= WORD_W) begin
         full.word  = stash[WORD_W-1:0];
         full.nbits = COUNT_W'(WORD_W);
         expected_words.push_back(full);
         stash = stash >> WORD_W;
         pos   = pos - WORD_W;
      end
      acc_bits = stash[WORD_W-1:0];
      acc_fill = pos[4:0];
   endtask

   // Work out what one accepted request word does to the packer.
   task automatic predict_packer(input logic [CMD_W-1:0] cmd, input logic [VALUE_W-1:0] value,
                                 input logic [WORD_W-1:0] raw, input logic [COUNT_W-1:0] count);
      int              n;
      int              blen;
      logic [63:0]     code;
      logic [31:0]     v;
      packed_word_type part;
      case (cmd)
         CMD_RAW: begin
            // counts above a word are clipped to a word; zero emits nothing
            n = (count > WORD_W) ? WORD_W : int'(count);
            if (n != 0) begin
               code = {32'd0, raw} & ((64'd1 << n) - 64'd1);
               append_code(code, n);
            end
         end
         CMD_ENCODE: begin
            // saturate, then (blen-1) zeros followed by v+1 in blen bits
            v = (value > VALUE_SAT) ? 32'(VALUE_SAT) : 32'(value);
            v = v + 32'd1;
            blen = 0;
            for (int i = 0; i < 32; i++)
               if (v[i]) blen = i + 1;
            append_code({32'd0, v}, 2 * blen - 1);
         end
         CMD_FLUSH: begin
            // an empty word flushes to nothing
            if (acc_fill != 0) begin
               part.word  = acc_bits;
               part.nbits = COUNT_W'(acc_fill);
               expected_words.push_back(part);
               acc_bits = '0;
               acc_fill = '0;
            end
         end
         default: begin
            // unused code: no output, state untouched
         end
      endcase
   endtask

   // ---------------------------------------------------------------------------
   // Checking
   // ---------------------------------------------------------------------------

   task automatic report_mismatch(input string what, input logic [31:0] want,
                                  input logic [31:0] got);
      fault_count++;
      $display("%0t mismatch %s: expected %h, got %h", $realtime, what, want, got);
   endtask

   // every result word taken off rsp_ch is matched against the oldest expectation
   always @(posedge clock) begin
      packed_word_type want;
      if (!reset && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
         if (expected_words.size() == 0) begin
            report_mismatch("unexpected result word", 32'd0, rsp_if.out_word);
         end else begin
            want = expected_words.pop_front();
            if (rsp_if.out_word !== want.word)
               report_mismatch("out_word", want.word, rsp_if.out_word);
            if (rsp_if.valid_bits !== want.nbits)
               report_mismatch("valid_bits", 32'(want.nbits), 32'(rsp_if.valid_bits));
         end
      end
   end

   // watchdog: counts cycles in which no word moves on either channel
   always @(posedge clock) begin
      if (reset || (req_if.valid === 1'b1 && req_if.ready === 1'b1) ||
          (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("timeout with %0d result words outstanding", expected_words.size());
            $display("[exp_golomb_bit_packer] ERROR");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------------------
   // Sink side: ready with random stall bursts
   // ---------------------------------------------------------------------------

   initial begin
      rsp_if.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (snk_idle_on && $urandom_range(0, 3) == 0) begin
            rsp_if.ready <= 1'b0;
            repeat ($urandom_range(1, 7) - 1) @(negedge clock);
         end else begin
            rsp_if.ready <= 1'b1;
         end
      end
   end

   // ---------------------------------------------------------------------------
   // Source side
   // ---------------------------------------------------------------------------

   // Present one request word and wait until it is taken. Valid stays high into
   // the next call unless a gap is drawn; payload carries noise during gaps.
   task automatic push_command(input logic [CMD_W-1:0] cmd, input logic [VALUE_W-1:0] value,
                               input logic [WORD_W-1:0] raw, input logic [COUNT_W-1:0] count);
      @(negedge clock);
      if (src_idle_on && $urandom_range(0, 3) == 0) begin
         req_if.valid     <= 1'b0;
         req_if.command   <= CMD_W'($urandom);
         req_if.value     <= VALUE_W'($urandom);
         req_if.raw_bits  <= $urandom;
         req_if.raw_count <= COUNT_W'($urandom);
         repeat ($urandom_range(1, 7)) @(negedge clock);
      end
      req_if.valid     <= 1'b1;
      req_if.command   <= cmd;
      req_if.value     <= value;
      req_if.raw_bits  <= raw;
      req_if.raw_count <= count;
      do @(posedge clock); while (req_if.ready !== 1'b1);
      predict_packer(cmd, value, raw, count);
   endtask

   // drop valid and let every outstanding result word come back
   task automatic hold_until_drained();
      @(negedge clock);
      req_if.valid <= 1'b0;
      wait (expected_words.size() == 0);
   endtask

   // random value spread over all code lengths, with the odd saturating one
   function automatic logic [VALUE_W-1:0] pick_value();
      int k;
      case ($urandom_range(0, 15))
         0:       return '1;
         1:       return VALUE_SAT;
         default: begin
            k = $urandom_range(1, VALUE_W);
            return VALUE_W'($urandom & ((1 << k) - 1));
         end
      endcase
   endfunction

   // raw bit count: mostly legal, sometimes zero or over a word
   function automatic logic [COUNT_W-1:0] pick_count();
      case ($urandom_range(0, 19))
         0:       return '0;
         1:       return COUNT_W'($urandom_range(33, 63));
         2:       return COUNT_W'(1);
         3:       return COUNT_W'(32);
         default: return COUNT_W'($urandom_range(1, 32));
      endcase
   endfunction

   // one random request word; weights in percent for raw, encode and flush,
   // the rest being the unused code
   task automatic push_random(input int raw_pct, input int enc_pct, input int flush_pct);
      int                 r;
      logic [CMD_W-1:0]   cmd;
      r = $urandom_range(0, 99);
      if (r < raw_pct)                             cmd = CMD_RAW;
      else if (r < raw_pct + enc_pct)              cmd = CMD_ENCODE;
      else if (r < raw_pct + enc_pct + flush_pct)  cmd = CMD_FLUSH;
      else                                         cmd = CMD_UNUSED;
      push_command(cmd, pick_value(), $urandom, pick_count());
   endtask

   // ---------------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------------

   // edge cases of every field and command, in a fixed order
   task automatic test_directed();
      push_command(CMD_FLUSH,  '0,        32'd0,         6'd0);  // flush of empty word
      push_command(CMD_RAW,    '0,        32'd1,         6'd1);
      push_command(CMD_RAW,    '1,        32'hFFFF_FFFF, 6'd32); // completes, 1 bit left
      push_command(CMD_RAW,    '0,        32'hFFFF_FFFF, 6'd0);  // zero count
      push_command(CMD_RAW,    '0,        32'hA5A5_5A5A, 6'd63); // clipped to a word
      push_command(CMD_RAW,    '0,        32'h0000_0000, 6'd33);
      push_command(CMD_ENCODE, 16'd0,     32'd0,         6'd0);
      push_command(CMD_ENCODE, 16'd1,     32'd0,         6'd0);
      push_command(CMD_ENCODE, 16'd2,     32'd0,         6'd0);
      push_command(CMD_ENCODE, VALUE_SAT, 32'd0,         6'd0);  // longest code
      push_command(CMD_ENCODE, '1,        32'd0,         6'd0);  // saturated value
      push_command(CMD_UNUSED, '1,        32'hFFFF_FFFF, '1);    // ignored
      push_command(CMD_FLUSH,  '0,        32'd0,         6'd0);  // partial word out
      push_command(CMD_FLUSH,  '1,        32'hFFFF_FFFF, '1);    // empty again
      push_command(CMD_RAW,    '0,        32'h8000_0001, 6'd32); // exactly one word
      push_command(CMD_RAW,    '0,        32'h7FFF_FFFF, 6'd31);
      push_command(CMD_RAW,    '0,        32'd1,         6'd1);  // fills to exactly 32
      push_command(CMD_ENCODE, 16'h8000,  32'd0,         6'd0);
      push_command(CMD_ENCODE, 16'h7FFF,  32'd0,         6'd0);
      push_command(CMD_RAW,    '0,        32'h5555_AAAA, 6'd17);
      push_command(CMD_FLUSH,  '0,        32'd0,         6'd0);
   endtask

   task automatic test_raw_stream();
      repeat (150) push_random(80, 5, 10);
   endtask

   task automatic test_encode_stream();
      repeat (150) push_random(5, 80, 10);
   endtask

   // mixed traffic, idling switched on and off in blocks, with one full drain
   task automatic test_mixed_stream();
      for (int blk = 0; blk < 6; blk++) begin
         src_idle_on = (blk % 3) != 2;
         snk_idle_on = (blk % 2) == 0;
         repeat (50) push_random(45, 40, 10);
         if (blk == 2) hold_until_drained();
      end
      src_idle_on = 1'b1;
      snk_idle_on = 1'b1;
   endtask

   // back-to-back traffic at full rate on both sides
   task automatic test_full_rate();
      src_idle_on = 1'b0;
      snk_idle_on = 1'b0;
      repeat (50) push_random(45, 40, 12);
      push_command(CMD_FLUSH, '0, 32'd0, 6'd0);
   endtask

   initial begin
      reset            = 1'b1;
      req_if.valid     = 1'b0;
      req_if.command   = CMD_RAW;
      req_if.value     = '0;
      req_if.raw_bits  = '0;
      req_if.raw_count = '0;
      acc_bits         = '0;
      acc_fill         = '0;
      fault_count      = 0;
      src_idle_on      = 1'b1;
      snk_idle_on      = 1'b1;

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed();
      test_raw_stream();
      test_encode_stream();
      test_mixed_stream();
      test_full_rate();

      @(negedge clock);
      req_if.valid <= 1'b0;
      wait (expected_words.size() == 0);
      repeat (TAIL_CYCLES) @(posedge clock);

      if (expected_words.size() != 0)
         report_mismatch("result words never arrived", 32'd0,
                         32'(expected_words.size()));

      if (fault_count == 0) begin
         $display("[exp_golomb_bit_packer] OK");
      end else begin
         $display("[exp_golomb_bit_packer] ERROR");
      end
      $finish;
   end

endmodule

### files.f
rtl/ego_pkg.sv
rtl/ego_req_if.sv
rtl/ego_rsp_if.sv
rtl/ego_code_gen.sv
rtl/ego_packer.sv
rtl/exp_golomb_bit_packer.sv
rtl/ego_checker.sv
tb/tb_top.sv
